@@ design/ptd_pkg.sv @@
// shared types, codes and defaults for the periodic task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

  // fixed field widths of the stream payloads
  localparam int TASK_ID_W  = 16;
  localparam int PERIOD_W   = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int ACTIVE_W   = 5;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 24;

  // defaults for the top level parameters
  localparam int SLOTS_DEF       = 24;
  localparam int ID_BITS_DEF     = 16;
  localparam int PERIOD_BITS_DEF = 16;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ROUND      = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_UNREGISTER,
    OP_CLEAR,
    OP_ROUND,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [TASK_ID_W-1:0] task_id;
    logic [PERIOD_W-1:0]  period;
  } entry_t;

  typedef struct packed {
    logic                 dispatch_valid;
    logic [TASK_ID_W-1:0] dispatch_id;
    logic [STATUS_W-1:0]  status;
    logic [ACTIVE_W-1:0]  active_count;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

@@ design/ptd_front.sv @@
// input side: classifies commands and queues them for the slot sequencer
`timescale 1ns / 1ps
`default_nettype none

module ptd_front #(
  parameter int ID_BITS     = ptd_pkg::ID_BITS_DEF,
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [ptd_pkg::CMD_W-1:0]     s_tuser_i,
  input  wire logic [ptd_pkg::S_DATA_W-1:0]  s_tdata_i,
  output logic                               q_valid_o,
  output ptd_pkg::entry_t                    q_entry_o,
  input  wire logic                          q_pop_i
);

  localparam int PTR_W = (ptd_pkg::QUEUE_DEPTH > 1) ? $clog2(ptd_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(ptd_pkg::QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ptd_pkg::QUEUE_DEPTH);

  logic [ptd_pkg::TASK_ID_W-1:0] task_id;
  logic [ptd_pkg::PERIOD_W-1:0]  period;
  logic                          id_zero;
  logic                          per_zero;
  ptd_pkg::op_e                  op;
  ptd_pkg::entry_t               entry_q [ptd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr_q;
  logic [PTR_W-1:0]              rd_ptr_q;
  logic [FILL_W-1:0]             fill_q;
  logic                          push;
  logic                          pop;

  assign task_id  = s_tdata_i[ptd_pkg::TASK_ID_W-1:0];
  assign period   = s_tdata_i[ptd_pkg::S_DATA_W-1:ptd_pkg::TASK_ID_W];
  // only the low ID_BITS / PERIOD_BITS of the fields take part
  assign id_zero  = (ID_BITS'(task_id) == '0);
  assign per_zero = (PERIOD_BITS'(period) == '0);

  always_comb begin
    unique case (s_tuser_i)
      ptd_pkg::CMD_REGISTER:   op = (id_zero || per_zero) ? ptd_pkg::OP_REJECT
                                                          : ptd_pkg::OP_REGISTER;
      ptd_pkg::CMD_UNREGISTER: op = id_zero ? ptd_pkg::OP_REJECT : ptd_pkg::OP_UNREGISTER;
      ptd_pkg::CMD_CLEAR:      op = ptd_pkg::OP_CLEAR;
      ptd_pkg::CMD_ROUND:      op = ptd_pkg::OP_ROUND;
      default:                 op = ptd_pkg::OP_ROUND;
    endcase
  end

  assign s_tready_o = (fill_q != FULL_FILL);
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op, task_id: task_id, period: period};
    end
  end

endmodule

`default_nettype wire

@@ design/ptd_back.sv @@
// slot table and sequencer: one slot per cycle unless stalled, emits results
`timescale 1ns / 1ps
`default_nettype none

module ptd_back #(
  parameter int SLOTS       = ptd_pkg::SLOTS_DEF,
  parameter int ID_BITS     = ptd_pkg::ID_BITS_DEF,
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire ptd_pkg::entry_t q_entry_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  input  wire logic      m_ready_i,
  output ptd_pkg::result_t m_result_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [PERIOD_BITS-1:0] TICK_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_q, state_d;
  ptd_pkg::op_e           op_q;
  logic [ID_BITS-1:0]     id_q;
  logic [PERIOD_BITS-1:0] per_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic                   free_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic                   pend_q;
  logic [ID_BITS-1:0]     pend_id_q;
  logic [SLOTS-1:0]       used_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [ID_BITS-1:0]     slot_id_q   [SLOTS];
  logic [PERIOD_BITS-1:0] slot_per_q  [SLOTS];
  logic [PERIOD_BITS-1:0] slot_tick_q [SLOTS];

  logic [ID_BITS-1:0]     rd_id;
  logic [PERIOD_BITS-1:0] rd_per;
  logic [PERIOD_BITS-1:0] rd_tick;
  logic                   rd_used;
  logic                   id_hit;
  logic                   tick_due;
  logic                   out_free;
  logic                   step;
  logic                   fin;
  logic                   take;
  logic                   fill_new;
  logic                   commit;
  logic [IDX_W-1:0]       wr_idx;

  logic                   emit;
  ptd_pkg::result_t       res;
  logic                   out_valid_q;
  ptd_pkg::result_t       out_q;

  assign rd_id    = slot_id_q[idx_q];
  assign rd_per   = slot_per_q[idx_q];
  assign rd_tick  = slot_tick_q[idx_q];
  assign rd_used  = used_q[idx_q];
  assign id_hit   = rd_used && (rd_id == id_q);
  assign tick_due = (rd_tick >= rd_per);

  // every step may emit one item, so it waits for room in the output register
  assign out_free = !out_valid_q || m_ready_i;
  assign step     = (state_q == ST_SCAN) && out_free;
  assign fin      = (state_q == ST_DONE) && out_free;
  assign take     = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o  = take;

  assign fill_new = !hit_q && free_q;
  assign commit   = fin && (op_q == ptd_pkg::OP_REGISTER) && (hit_q || free_q);
  assign wr_idx   = hit_q ? hit_idx_q : free_idx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (q_entry_i.op == ptd_pkg::OP_REGISTER || q_entry_i.op == ptd_pkg::OP_UNREGISTER
              || q_entry_i.op == ptd_pkg::OP_ROUND) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: if (step && idx_q == LAST_IDX) state_d = ST_DONE;
      ST_DONE: if (fin) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result item for this cycle, if any
  always_comb begin
    emit               = 1'b0;
    res.dispatch_valid = 1'b0;
    res.dispatch_id    = '0;
    res.status         = ptd_pkg::STATUS_OK;
    res.active_count   = ptd_pkg::ACTIVE_W'(cnt_q);
    res.last           = 1'b1;
    if (step && op_q == ptd_pkg::OP_ROUND && rd_used && tick_due && pend_q) begin
      // a later due slot exists, so the held dispatch is not the last
      emit               = 1'b1;
      res.dispatch_valid = 1'b1;
      res.dispatch_id    = ptd_pkg::TASK_ID_W'(pend_id_q);
      res.last           = 1'b0;
    end
    if (fin) begin
      emit = 1'b1;
      case (op_q)
        ptd_pkg::OP_ROUND: begin
          res.dispatch_valid = pend_q;
          res.dispatch_id    = pend_q ? ptd_pkg::TASK_ID_W'(pend_id_q) : '0;
        end
        ptd_pkg::OP_REGISTER: begin
          res.status = (hit_q || free_q) ? ptd_pkg::STATUS_OK : ptd_pkg::STATUS_FULL;
          if (fill_new) res.active_count = ptd_pkg::ACTIVE_W'(cnt_q + CNT_W'(1));
        end
        ptd_pkg::OP_REJECT: res.status = ptd_pkg::STATUS_INVALID;
        default:            res.status = ptd_pkg::STATUS_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ptd_pkg::OP_ROUND;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      pend_q      <= 1'b0;
      used_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        op_q   <= q_entry_i.op;
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        pend_q <= 1'b0;
        if (q_entry_i.op == ptd_pkg::OP_CLEAR) begin
          used_q <= '0;
          cnt_q  <= '0;
        end
      end
      if (step) begin
        if (idx_q != LAST_IDX) idx_q <= idx_q + IDX_W'(1);
        case (op_q)
          ptd_pkg::OP_REGISTER: begin
            if (id_hit && !hit_q)   hit_q  <= 1'b1;
            if (!rd_used && !free_q) free_q <= 1'b1;
          end
          ptd_pkg::OP_UNREGISTER: begin
            if (id_hit) begin
              used_q[idx_q] <= 1'b0;
              cnt_q         <= cnt_q - CNT_W'(1);
            end
          end
          ptd_pkg::OP_ROUND: begin
            if (rd_used && tick_due) pend_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (commit && fill_new) begin
        used_q[free_idx_q] <= 1'b1;
        cnt_q              <= cnt_q + CNT_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and slot table, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      id_q  <= ID_BITS'(q_entry_i.task_id);
      per_q <= PERIOD_BITS'(q_entry_i.period);
    end
    if (step && op_q == ptd_pkg::OP_REGISTER) begin
      if (id_hit && !hit_q)    hit_idx_q  <= idx_q;
      if (!rd_used && !free_q) free_idx_q <= idx_q;
    end
    if (step && op_q == ptd_pkg::OP_ROUND && rd_used) begin
      if (tick_due) begin
        pend_id_q          <= rd_id;
        // reset to zero, then the round's advance
        slot_tick_q[idx_q] <= PERIOD_BITS'(1);
      end else if (rd_tick != TICK_MAX) begin
        slot_tick_q[idx_q] <= rd_tick + PERIOD_BITS'(1);
      end
    end
    if (commit) begin
      slot_id_q[wr_idx]   <= id_q;
      slot_per_q[wr_idx]  <= per_q;
      slot_tick_q[wr_idx] <= '0;
    end
    if (emit) out_q <= res;
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

endmodule

`default_nettype wire

@@ design/periodic_task_dispatcher_top.sv @@
// top level of the periodic task dispatcher: command stream in, result stream out
//
// Slave channel takes one command per item: tuser carries the command (register,
// unregister, clear all, scheduling round), tdata carries task id and period.
// Master channel returns result items: tuser flags a dispatch, tlast marks the
// final item of a command. A round yields one item per due task in slot order,
// or a single empty item when none is due; every other command yields one item.
// Commands pass a two-entry queue into a sequencer that visits one slot per
// cycle while the output register has room; it takes the next command only
// once the last is done. Register, unregister and round walk all slots, while
// clear and rejected commands skip the walk, so the single slot walk sets the
// rate. The final item of a command leaves the sequencer from its done state.
// A round holds each dispatch until the walk finds the next due task or ends.
// Reset empties the table and the queue; no clearing pass is needed, since
// slot occupancy flags are flip-flops. When the receiver holds tready low the
// output register holds its item, the walk pauses, and once the queue fills
// s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher_top #(
  parameter int SLOTS       = ptd_pkg::SLOTS_DEF,
  parameter int ID_BITS     = ptd_pkg::ID_BITS_DEF,
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // command[1:0]
  input  wire logic [ptd_pkg::CMD_W-1:0]    s_axis_tuser,
  // task_id[15:0], period[31:16]
  input  wire logic [ptd_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // dispatch_valid[0]
  output logic                              m_axis_tuser,
  // dispatch_id[15:0], status[17:16], active_count[22:18], zero[23]
  output logic [ptd_pkg::M_DATA_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast
);

  logic             q_valid;
  ptd_pkg::entry_t  q_entry;
  logic             q_pop;
  ptd_pkg::result_t result;

  ptd_front #(
    .ID_BITS     (ID_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tuser_i  (s_axis_tuser),
    .s_tdata_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  ptd_back #(
    .SLOTS       (SLOTS),
    .ID_BITS     (ID_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tuser = result.dispatch_valid;
  assign m_axis_tlast = result.last;
  assign m_axis_tdata = {1'b0, result.active_count, result.status, result.dispatch_id};

  // a dispatch always reports success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[17:16] == ptd_pkg::STATUS_OK)
    else $error("dispatch item with non-ok status");

  // a dispatched task never carries the reserved id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] != '0)
    else $error("dispatch item with id zero");

  // an item without a dispatch is the only item of its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[15:0] == '0)
    else $error("non-dispatch item not final or carries an id");

endmodule

`default_nettype wire

@@ tb/sv/ptd_checker.sv @@
// stream checker for the periodic task dispatcher: predicts results and compares them
`timescale 1ns / 1ps

module ptd_checker
  import ptd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  m_axis_tuser,
  input  wire logic [M_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                  m_axis_tlast,
  output int                         errors_o,
  output int                         pending_o
);

  // private copy of the slot table
  logic                 slot_busy  [SLOTS];
  logic [TASK_ID_W-1:0] slot_task  [SLOTS];
  logic [PERIOD_W-1:0]  slot_every [SLOTS];
  logic [PERIOD_W-1:0]  slot_ticks [SLOTS];
  logic [ACTIVE_W-1:0]  busy_count;

  result_t reply_q [$];
  int      mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 60)
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_task[i]  = '0;
      slot_every[i] = '0;
      slot_ticks[i] = '0;
    end
    busy_count = '0;
  endfunction

  function automatic logic [STATUS_W-1:0] enroll_task(input logic [TASK_ID_W-1:0] id,
                                                      input logic [PERIOD_W-1:0] per);
    logic placed;
    placed = 1'b0;
    if (id == '0 || per == '0) return STATUS_INVALID;
    // an id already present gets its period refreshed and its tick count cleared
    for (int i = 0; i < SLOTS; i++) begin
      if (!placed && slot_busy[i] && slot_task[i] == id) begin
        slot_every[i] = per;
        slot_ticks[i] = '0;
        placed = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!placed && !slot_busy[i]) begin
        slot_busy[i]  = 1'b1;
        slot_task[i]  = id;
        slot_every[i] = per;
        slot_ticks[i] = '0;
        busy_count++;
        placed = 1'b1;
      end
    end
    return placed ? STATUS_OK : STATUS_FULL;
  endfunction

  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [TASK_ID_W-1:0] id,
                                        input logic [PERIOD_W-1:0] per);
    result_t r;
    logic    due [SLOTS];
    int      n_due;
    int      k;
    r      = '0;
    r.last = 1'b1;
    n_due  = 0;
    k      = 0;
    case (cmd)
      CMD_ROUND: begin
        for (int i = 0; i < SLOTS; i++) begin
          due[i] = slot_busy[i] && slot_ticks[i] >= slot_every[i];
          if (due[i]) begin
            slot_ticks[i] = '0;
            n_due++;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_ticks[i] != '1) slot_ticks[i]++;
        end
        r.status       = STATUS_OK;
        r.active_count = busy_count;
        if (n_due == 0) begin
          reply_q.push_back(r);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (due[i]) begin
              k++;
              r.dispatch_valid = 1'b1;
              r.dispatch_id    = slot_task[i];
              r.last           = (k == n_due);
              reply_q.push_back(r);
            end
          end
        end
      end
      CMD_REGISTER: begin
        r.status       = enroll_task(id, per);
        r.active_count = busy_count;
        reply_q.push_back(r);
      end
      CMD_UNREGISTER: begin
        if (id == '0) begin
          r.status = STATUS_INVALID;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_task[i] == id) begin
              slot_busy[i] = 1'b0;
              if (busy_count != '0) busy_count--;
            end
          end
          r.status = STATUS_OK;
        end
        r.active_count = busy_count;
        reply_q.push_back(r);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
        busy_count     = '0;
        r.status       = STATUS_OK;
        r.active_count = busy_count;
        reply_q.push_back(r);
      end
    endcase
  endfunction

  task automatic check_result();
    result_t want;
    if (reply_q.size() == 0) begin
      report_mismatch("unexpected result item", m_axis_tdata, 0);
    end else begin
      want = reply_q.pop_front();
      if (m_axis_tuser != want.dispatch_valid)
        report_mismatch("dispatch_valid", m_axis_tuser, want.dispatch_valid);
      if (m_axis_tdata[15:0] != want.dispatch_id)
        report_mismatch("dispatch_id", m_axis_tdata[15:0], want.dispatch_id);
      if (m_axis_tdata[17:16] != want.status)
        report_mismatch("status", m_axis_tdata[17:16], want.status);
      if (m_axis_tdata[22:18] != want.active_count)
        report_mismatch("active_count", m_axis_tdata[22:18], want.active_count);
      if (m_axis_tdata[23] != 1'b0)
        report_mismatch("tdata pad bit", m_axis_tdata[23], 0);
      if (m_axis_tlast != want.last)
        report_mismatch("last", m_axis_tlast, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      reply_q.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (m_axis_tvalid && m_axis_tready) check_result();
      errors_o  <= mismatches;
      pending_o <= reply_q.size();
    end
  end

endmodule

@@ tb/sv/periodic_task_dispatcher_top_tb.sv @@
// testbench top for the periodic task dispatcher: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module periodic_task_dispatcher_top_tb;
  import ptd_pkg::*;

  localparam int NUM_ITEMS   = 330;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SQUEEZE_LEN = 400;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CMD_W-1:0]    s_axis_tuser  = '0;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                m_axis_tuser;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int errors;
  int pending;
  int sent;
  int cycle_count;
  bit calm_tx;
  bit calm_rx;
  bit squeeze_req;
  bit squeeze_done;

  periodic_task_dispatcher_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ptd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TASK_ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return TASK_ID_W'($urandom_range(1, 40));
    if (r < 95) return TASK_ID_W'($urandom_range(1, 65535));
    return 16'hFFFF;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return PERIOD_W'($urandom_range(1, 5));
    if (r < 90) return PERIOD_W'($urandom_range(6, 40));
    if (r < 97) return PERIOD_W'($urandom_range(1, 65535));
    return 16'hFFFF;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TASK_ID_W-1:0] id,
                          input logic [PERIOD_W-1:0] per);
    int g;
    if ($urandom_range(0, 29) == 0) calm_tx = ~calm_tx;
    g = calm_tx ? 0 : gap_cycles();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {per, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    if (sent == 120) squeeze_req = 1'b1;
  endtask

  task automatic send_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      send_cmd(CMD_REGISTER, pick_id(), pick_period());
    else if (r < 70) send_cmd(CMD_ROUND, pick_id(), pick_period());
    else if (r < 82) send_cmd(CMD_UNREGISTER, pick_id(), pick_period());
    else if (r < 85) send_cmd(CMD_CLEAR, pick_id(), pick_period());
    else if (r < 89) send_cmd(CMD_REGISTER, '0, pick_period());
    else if (r < 93) send_cmd(CMD_REGISTER, pick_id(), '0);
    else if (r < 95) send_cmd(CMD_UNREGISTER, '0, pick_period());
    else             send_cmd(CMD_W'($urandom_range(0, 3)), TASK_ID_W'($urandom),
                              PERIOD_W'($urandom));
  endtask

  // fill the table up to or past its capacity with short periods, then run rounds
  task automatic fill_table();
    int base;
    int n;
    base = $urandom_range(1, 65000);
    n    = $urandom_range(22, 28);
    if ($urandom_range(0, 1) == 1) send_cmd(CMD_CLEAR, '0, '0);
    for (int k = 0; k < n; k++) begin
      send_cmd(CMD_REGISTER, TASK_ID_W'(base + k), PERIOD_W'($urandom_range(1, 4)));
      if ($urandom_range(0, 5) == 0) send_cmd(CMD_ROUND, '0, '0);
    end
    repeat ($urandom_range(2, 5)) send_cmd(CMD_ROUND, pick_id(), pick_period());
  endtask

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int g;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 49) == 0) calm_rx = ~calm_rx;
        g = calm_rx ? 0 : gap_cycles();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, rejected ids and periods, absent id, extremes, update in place
    send_cmd(CMD_ROUND, '0, '0);
    send_cmd(CMD_REGISTER, '0, 16'd3);
    send_cmd(CMD_REGISTER, 16'd7, '0);
    send_cmd(CMD_UNREGISTER, '0, 16'hFFFF);
    send_cmd(CMD_UNREGISTER, 16'd99, 16'd1);
    send_cmd(CMD_REGISTER, 16'hFFFF, 16'd1);
    send_cmd(CMD_REGISTER, 16'd1, 16'hFFFF);
    send_cmd(CMD_REGISTER, 16'hFFFF, 16'd2);
    send_cmd(CMD_REGISTER, 16'h5AA5, 16'd1);
    send_cmd(CMD_ROUND, '0, '0);
    send_cmd(CMD_ROUND, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ROUND, '0, '0);
    send_cmd(CMD_UNREGISTER, 16'd1, '0);
    send_cmd(CMD_ROUND, '0, '0);
    send_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ROUND, '0, '0);

    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        fill_table();
      end else begin
        repeat ($urandom_range(10, 30)) send_random_cmd();
      end
    end
    s_axis_tvalid <= 1'b0;

    // the checker's pending count is registered
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
